### sv/tbbt_pkg.sv
// Shared types, constants and helper functions for the tape block biphase transmitter.
// Depends on nothing; every other file in this block refers to it by scoped names.
package tbbt_pkg;

  localparam int MAX_PAYLOAD_DEF = 254;

  localparam logic [7:0]  SYNC_BYTE  = 8'h01;
  localparam logic [7:0]  MARK_ONE   = 8'h3C;
  localparam logic [7:0]  MARK_TWO   = 8'h5A;
  localparam logic [4:0]  SYNC_LIMIT = 5'd16;

  localparam logic [4:0]  LEAD_RST   = 5'd3;
  localparam logic [15:0] PERIOD_RST = 16'd9582;
  localparam logic [15:0] MID_RST    = 16'd4750;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_LEAD   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_MID    = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic load_done;
    logic frame_done;
  } result_t;

  // Number of leading sync bytes, capped at the sync limit.
  function automatic logic [4:0] lead_len(input logic [4:0] lead);
    return (lead > SYNC_LIMIT) ? SYNC_LIMIT : lead;
  endfunction

  // Byte of the frame at a given position; pay is the stored payload byte
  // for that position, which is only meaningful inside the payload range.
  function automatic logic [7:0] frame_byte(
    input logic [8:0] pos,
    input logic [4:0] lead,
    input logic [7:0] typ,
    input logic [7:0] cnt,
    input logic [7:0] pay,
    input logic [7:0] csum
  );
    logic [9:0] p;
    logic [9:0] q;
    logic [7:0] b;
    p = {1'b0, pos} - {5'b0, lead};
    q = p - 10'd4;
    if ({1'b0, pos} < {5'b0, lead}) begin
      b = SYNC_BYTE;
    end else if (p == 10'd0) begin
      b = MARK_ONE;
    end else if (p == 10'd1) begin
      b = MARK_TWO;
    end else if (p == 10'd2) begin
      b = typ;
    end else if (p == 10'd3) begin
      b = cnt + 8'd2;
    end else if (q < {2'b0, cnt}) begin
      b = pay;
    end else begin
      b = csum;
    end
    return b;
  endfunction

endpackage

### sv/tape_block_biphase_transmitter_unit.sv
// Top level of the tape block biphase transmitter: loading, framing and line coding.
// Depends on tbbt_pkg for constants, the result struct and the frame byte function.
//
// Usage: the input channel (in_valid/in_stall) carries one item per transfer:
// a block start (type and length), a payload byte, or one timer tick. Every
// accepted item produces exactly one result transfer on the output channel
// (out_valid/out_stall) with the line level after the item, the busy flag and
// the load/frame completion flags. Payload bytes are kept in a single-port
// write, single-port read synchronous memory; while a frame is sent, the
// memory is read continuously one byte ahead so that the byte needed at the
// next cell boundary is already registered.
// Each result is registered in the output buffer described below.
// Throughput: one item per clock while in_stall is low; state is updated in the cycle of transfer.
// A two-entry output buffer lets the block keep taking items while one result
// waits; in_stall rises only once both entries are full, and the results are
// delivered in order when the receiver drops out_stall.
// Reset (rst_n low, synchronous) leaves the line high, the block idle and
// the registers at their defaults (3 sync bytes, period 9582, mid point 4750).
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at once.
module tape_block_biphase_transmitter_unit #(
  parameter int MAX_PAYLOAD = tbbt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_block_type,
  input  logic [7:0]  in_data_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_level,
  output logic        out_busy_res,
  output logic        out_load_done,
  output logic        out_frame_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Configuration registers.
  logic [4:0]  lead_r, lead_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] mid_r, mid_nxt;

  // Block state.
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  widx_r, widx_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [8:0]  send_r, send_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        cur_bit_r, cur_bit_nxt;
  logic        line_r, line_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        sending_r, sending_nxt;
  logic        loading_r, loading_nxt;

  // Payload memory.
  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rd_q;
  logic          mem_we;
  logic [AW-1:0] rd_addr;

  // Output buffer.
  tbbt_pkg::result_t e0_r, e0_nxt, e1_r, e1_nxt, res;
  logic [1:0] cnt_r, cnt_nxt;

  logic             push, pop;
  logic             load_done, frame_done, begin_blk;
  logic [7:0]       len_sat, widx_inc, cur_byte, first_byte;
  logic [15:0]      tick_inc;
  logic [4:0]       lead_cur;
  logic [8:0]       pos_sel, pos_rd, send_step;
  logic [9:0]       flen, rd_full;
  tbbt_pkg::action_t act;

  assign push     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = (cnt_r == 2'd2);
  assign act      = tbbt_pkg::action_t'(in_action);

  // Configuration next values.
  always_comb begin
    lead_nxt   = lead_r;
    period_nxt = period_r;
    mid_nxt    = mid_r;
    if (cfg_we) begin
      case (tbbt_pkg::reg_idx_t'(cfg_index))
        tbbt_pkg::REG_LEAD:   lead_nxt   = cfg_wdata[4:0];
        tbbt_pkg::REG_PERIOD: period_nxt = cfg_wdata;
        tbbt_pkg::REG_MID:    mid_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lead_cur = tbbt_pkg::lead_len(lead_r);
  assign len_sat  = (in_data_length > MAX_LEN) ? MAX_LEN : in_data_length;
  assign widx_inc = widx_r + 8'd1;
  assign tick_inc = tick_r + 16'd1;
  assign flen     = {5'b0, lead_cur} + 10'd5 + {2'b0, count_r};

  // While bit 0 is on the line the next boundary moves to the following byte,
  // and rd_q already holds the payload entry for that position.
  assign pos_sel  = (bit_r == 3'd0) ? (send_r + 9'd1) : send_r;
  assign cur_byte = tbbt_pkg::frame_byte(pos_sel, lead_cur, type_r, count_r, rd_q, csum_r);
  assign first_byte = tbbt_pkg::frame_byte(9'd0, lead_cur, type_r, count_r, rd_q, csum_r);
  assign send_step  = pos_sel;

  always_comb begin
    type_nxt    = type_r;
    count_nxt   = count_r;
    widx_nxt    = widx_r;
    csum_nxt    = csum_r;
    send_nxt    = send_r;
    bit_nxt     = bit_r;
    cur_bit_nxt = cur_bit_r;
    line_nxt    = line_r;
    tick_nxt    = tick_r;
    sending_nxt = sending_r;
    loading_nxt = loading_r;
    mem_we      = 1'b0;
    load_done   = 1'b0;
    frame_done  = 1'b0;
    begin_blk   = 1'b0;
    if (push) begin
      case (act)
        tbbt_pkg::ACT_START: begin
          if (!sending_r) begin
            type_nxt    = in_block_type;
            count_nxt   = len_sat;
            widx_nxt    = 8'd0;
            csum_nxt    = 8'd0;
            loading_nxt = 1'b1;
            begin_blk   = (len_sat == 8'd0);
          end
        end
        tbbt_pkg::ACT_DATA: begin
          if (loading_r && !sending_r) begin
            mem_we    = 1'b1;
            csum_nxt  = csum_r - in_data_byte;
            widx_nxt  = widx_inc;
            begin_blk = (widx_inc >= count_r);
          end
        end
        tbbt_pkg::ACT_TICK: begin
          if (sending_r) begin
            tick_nxt = tick_inc;
            if (tick_inc < period_r) begin
              if (tick_inc == mid_r && cur_bit_r) line_nxt = !line_r;
            end else begin
              tick_nxt = 16'd0;
              bit_nxt  = bit_r - 3'd1;
              send_nxt = send_step;
              if ({1'b0, send_step} >= flen) begin
                line_nxt    = 1'b1;
                sending_nxt = 1'b0;
                send_nxt    = 9'd0;
                bit_nxt     = 3'd7;
                frame_done  = 1'b1;
              end else begin
                line_nxt    = !line_r;
                cur_bit_nxt = cur_byte[bit_r - 3'd1];
              end
            end
          end
        end
        default: ;
      endcase
      // The first byte of a frame is never a payload byte, so no memory read
      // is needed when the block starts.
      if (begin_blk) begin
        loading_nxt = 1'b0;
        sending_nxt = 1'b1;
        send_nxt    = 9'd0;
        bit_nxt     = 3'd7;
        tick_nxt    = 16'd0;
        line_nxt    = !line_r;
        cur_bit_nxt = first_byte[7];
        load_done   = 1'b1;
      end
    end
  end

  // Read address follows the next state so that rd_q matches the registers
  // in every cycle, including right after a configuration write.
  assign pos_rd  = (bit_nxt == 3'd0) ? (send_nxt + 9'd1) : send_nxt;
  assign rd_full = {1'b0, pos_rd} - {5'b0, tbbt_pkg::lead_len(lead_nxt)} - 10'd4;
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx_r[AW-1:0]] <= in_data_byte;
    end
    rd_q <= mem[rd_addr];
  end

  assign res.line_level = line_nxt;
  assign res.busy_res   = sending_nxt;
  assign res.load_done  = load_done;
  assign res.frame_done = frame_done;

  // Two-entry output buffer, e0 is the head.
  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          e0_nxt  = res;
          cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          e0_nxt = res;
        end else if (push) begin
          e1_nxt  = res;
          cnt_nxt = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          e0_nxt  = e1_r;
          cnt_nxt = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_line_level = e0_r.line_level;
  assign out_busy_res   = e0_r.busy_res;
  assign out_load_done  = e0_r.load_done;
  assign out_frame_done = e0_r.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r    <= tbbt_pkg::LEAD_RST;
      period_r  <= tbbt_pkg::PERIOD_RST;
      mid_r     <= tbbt_pkg::MID_RST;
      type_r    <= 8'd0;
      count_r   <= 8'd0;
      widx_r    <= 8'd0;
      csum_r    <= 8'd0;
      send_r    <= 9'd0;
      bit_r     <= 3'd7;
      cur_bit_r <= 1'b1;
      line_r    <= 1'b1;
      tick_r    <= 16'd0;
      sending_r <= 1'b0;
      loading_r <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      lead_r    <= lead_nxt;
      period_r  <= period_nxt;
      mid_r     <= mid_nxt;
      type_r    <= type_nxt;
      count_r   <= count_nxt;
      widx_r    <= widx_nxt;
      csum_r    <= csum_nxt;
      send_r    <= send_nxt;
      bit_r     <= bit_nxt;
      cur_bit_r <= cur_bit_nxt;
      line_r    <= line_nxt;
      tick_r    <= tick_nxt;
      sending_r <= sending_nxt;
      loading_r <= loading_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule
